/* hdl/bgm_pkg.sv */
`default_nettype none
package bgm_pkg;

  localparam int unsigned ADC_W  = 12;
  localparam int unsigned VOLT_W = 10;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned CAP_W  = 13;
  localparam int unsigned DIV_W  = 24;

  localparam logic [VOLT_W-1:0] V_SAT      = 10'd999;
  localparam logic [VOLT_W-1:0] V_LOW      = 10'd520;
  localparam logic [VOLT_W-1:0] V_HYST_TOP = 10'd570;
  localparam logic [VOLT_W-1:0] V_FULL     = 10'd840;
  localparam logic [VOLT_W-1:0] V_HEALTH   = 10'd760;

  // calibration voltages, 10 mV units
  function automatic logic [VOLT_W-1:0] cal_volt(input logic [2:0] idx);
    logic [VOLT_W-1:0] v;
    case (idx)
      3'd0:    v = 10'd520;
      3'd1:    v = 10'd689;
      3'd2:    v = 10'd724;
      3'd3:    v = 10'd760;
      default: v = 10'd771;
    endcase
    return v;
  endfunction

  // register indexes
  localparam logic [2:0] REG_CAL0 = 3'd0;
  localparam logic [2:0] REG_CAL4 = 3'd4;
  localparam logic [2:0] REG_CAP  = 3'd5;

  // datapath commands
  typedef struct packed {
    logic load;      // capture request, compute average and segment
    logic div_start; // kick the current step
    logic [2:0] step;
    logic finish;    // never driven by the controller; unused by the datapath
  } bgm_cmd_t;

  typedef struct packed {
    logic div_done;  // current step finished
  } bgm_sts_t;

  localparam logic [2:0] STEP_VOLT   = 3'd0;
  localparam logic [2:0] STEP_PCT    = 3'd1;
  localparam logic [2:0] STEP_HEALTH = 3'd2;
  localparam logic [2:0] STEP_EFF    = 3'd3;
  localparam logic [2:0] STEP_REM    = 3'd4;

endpackage
`default_nettype wire

/* hdl/bgm_divider.sv */
`default_nettype none
module bgm_divider import bgm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] num_i,
  input  wire logic [DIV_W-1:0] den_i,
  output logic                  done_o,
  output logic [DIV_W-1:0]      quo_o
);
  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [DIV_W:0]   trial;

  // restoring division, one quotient bit a cycle
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = '0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
      cnt_d  = CNT_W'(DIV_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[DIV_W-1]} - {1'b0, den_q};
      if (!trial[DIV_W]) begin
        rem_d = trial[DIV_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DIV_W-2:0], quo_q[DIV_W-1]};
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

/* hdl/bgm_datapath.sv */
`default_nettype none
module bgm_datapath import bgm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bgm_cmd_t          cmd_i,
  output bgm_sts_t               sts_o,
  input  wire logic              kind_i,
  input  wire logic [ADC_W-1:0]  sample_0_i,
  input  wire logic [ADC_W-1:0]  sample_1_i,
  input  wire logic [ADC_W-1:0]  sample_2_i,
  input  wire logic [ADC_W-1:0]  sample_3_i,
  input  wire logic [ADC_W-1:0]  cal_i [5],
  input  wire logic [CAP_W-1:0]  cap_i,
  output logic [ADC_W-1:0]       avg_o,
  output logic [VOLT_W-1:0]      volt_o,
  output logic [PCT_W-1:0]       pct_o,
  output logic [2:0]             level_o,
  output logic [PCT_W-1:0]       health_o,
  output logic [CAP_W-1:0]       rem_o,
  output logic                   low_o,
  output logic                   blink_o
);
  // ceil(2^26/100) and ceil(2^16/12); exact floors over the operand ranges used
  localparam logic [19:0] RECIP_100 = 20'd671089;
  localparam logic [12:0] RECIP_12  = 13'd5462;

  logic [ADC_W-1:0]  avg_q;
  logic [VOLT_W-1:0] volt_q, base_q;
  logic              kind_q, div_v_q, lowv_q;
  logic [DIV_W-1:0]  vnum_q, vden_q;
  logic              low_q, blink_q;
  logic [PCT_W-1:0]  pct_q, health_q;
  logic [15:0]       eff_q;
  logic [CAP_W-1:0]  rem_q;
  logic [2:0]        level_q;
  logic [19:0]       prod_q, prod_d;
  logic              calc_done_q;

  logic [ADC_W+1:0]  sum;
  logic [ADC_W-1:0]  avg_n;
  logic [1:0]        seg;
  logic [ADC_W-1:0]  p_lo, p_hi, pden;
  logic [VOLT_W-1:0] v_lo, dv;
  logic [DIV_W-1:0]  quo;
  logic              div_done, div_go, step_done;
  logic [VOLT_W:0]   vsum;
  logic [VOLT_W-1:0] v_new, dvv;
  logic [39:0]       q100;
  logic [23:0]       q12;

  assign sum   = {2'b0, sample_0_i} + {2'b0, sample_1_i}
               + {2'b0, sample_2_i} + {2'b0, sample_3_i} + 14'd2;
  assign avg_n = sum[ADC_W+1:2];

  always_comb begin
    seg = 2'd3;
    if (avg_n <= cal_i[1])      seg = 2'd0;
    else if (avg_n <= cal_i[2]) seg = 2'd1;
    else if (avg_n <= cal_i[3]) seg = 2'd2;
    p_lo = cal_i[seg];
    p_hi = cal_i[3'(seg) + 3'd1];
    v_lo = cal_volt(3'(seg));
    dv   = cal_volt(3'(seg) + 3'd1) - v_lo;
    pden = p_hi - p_lo;
  end

  // operands of the later steps, registered at the kick cycle;
  // (d*100+160)/320 = (d*5+8)/16 and (d*100+120)/240 = (d*5+6)/12
  always_comb begin
    dvv    = volt_q - V_LOW;
    prod_d = '0;
    case (cmd_i.step)
      STEP_PCT:    prod_d = 20'(dvv) * 20'd5 + 20'd8;
      STEP_HEALTH: prod_d = 20'(dvv) * 20'd5 + 20'd6;
      STEP_EFF:    prod_d = 20'(cap_i) * 20'(health_q);
      STEP_REM:    prod_d = 20'(eff_q) * 20'(pct_q);
      default: ;
    endcase
  end

  assign q100 = 40'(prod_q) * 40'(RECIP_100);
  assign q12  = 24'(prod_q) * 24'(RECIP_12);

  // only the voltage step needs a true division
  assign div_go = cmd_i.div_start && (cmd_i.step == STEP_VOLT);

  bgm_divider u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_go),
    .num_i(vnum_q), .den_i(vden_q), .done_o(div_done), .quo_o(quo)
  );
  assign step_done      = div_done || calc_done_q;
  assign sts_o.div_done = step_done;

  assign vsum  = {1'b0, base_q} + quo[VOLT_W:0];
  always_comb begin
    if (!div_v_q)                          v_new = base_q;
    else if (quo > DIV_W'(V_SAT) || vsum > {1'b0, V_SAT}) v_new = V_SAT;
    else                                   v_new = vsum[VOLT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) prod_q <= prod_d;
    if (cmd_i.load) begin
      kind_q <= kind_i;
      if (!kind_i) begin
        if (avg_n < cal_i[0] || cal_i[0] == '0 || cal_i[3] == '0) begin
          div_v_q <= 1'b1;
          base_q  <= '0;
          vnum_q  <= DIV_W'(avg_n) * DIV_W'(760) + DIV_W'(2047);
          vden_q  <= DIV_W'(4095);
        end else begin
          div_v_q <= p_hi > p_lo;
          base_q  <= v_lo;
          vnum_q  <= DIV_W'(avg_n - p_lo) * DIV_W'(dv) + DIV_W'(pden >> 1);
          vden_q  <= DIV_W'(pden);
        end
      end
    end
    if (step_done) begin
      case (cmd_i.step)
        STEP_PCT: begin
          pct_q <= (volt_q <= V_LOW) ? '0 : (volt_q >= V_FULL) ? PCT_W'(100)
                   : prod_q[PCT_W+3:4];
        end
        STEP_HEALTH: begin
          health_q <= (volt_q <= V_LOW) ? '0 : (volt_q >= V_HEALTH) ? PCT_W'(100)
                      : q12[PCT_W+15:16];
          // level = (pct*6+50)/100 via small compare chain
          level_q <= (pct_q >= 7'd92) ? 3'd6 : (pct_q >= 7'd75) ? 3'd5 :
                     (pct_q >= 7'd59) ? 3'd4 : (pct_q >= 7'd42) ? 3'd3 :
                     (pct_q >= 7'd25) ? 3'd2 : (pct_q >= 7'd9)  ? 3'd1 : 3'd0;
        end
        STEP_EFF: eff_q <= 16'(q100[39:26]);
        STEP_REM: rem_q <= q100[26+CAP_W-1:26];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q       <= '0;
      volt_q      <= '0;
      low_q       <= 1'b0;
      blink_q     <= 1'b0;
      calc_done_q <= 1'b0;
    end else begin
      calc_done_q <= cmd_i.div_start && (cmd_i.step != STEP_VOLT);
      if (cmd_i.load && !kind_i) avg_q <= avg_n;
      if (div_done && cmd_i.step == STEP_VOLT && !kind_q) volt_q <= v_new;
      if (cmd_i.load && kind_i) begin
        if (volt_q <= V_LOW) begin
          low_q   <= 1'b1;
          blink_q <= ~blink_q;
        end else if (volt_q > V_HYST_TOP) begin
          low_q   <= 1'b0;
          blink_q <= 1'b0;
        end
      end
    end
  end

  assign avg_o    = avg_q;
  assign volt_o   = volt_q;
  assign pct_o    = pct_q;
  assign level_o  = level_q;
  assign health_o = health_q;
  assign rem_o    = rem_q;
  assign low_o    = low_q;
  assign blink_o  = blink_q;
endmodule
`default_nettype wire

/* hdl/bgm_ctrl.sv */
`default_nettype none
module bgm_ctrl import bgm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire bgm_sts_t sts_i,
  output bgm_cmd_t  cmd_o
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_KICK = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic [2:0] step_q, step_d;
  logic       ovalid_q, ovalid_d;

  assign in_ready_o = (state_q == S_IDLE) && !ovalid_q;

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o    = '0;
    cmd_o.step = step_q;
    case (state_q)
      S_IDLE: if (in_valid_i && in_ready_o) begin
        cmd_o.load = 1'b1;
        step_d  = STEP_VOLT;
        state_d = S_KICK;
      end
      S_KICK: begin
        cmd_o.div_start = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: if (sts_i.div_done) begin
        if (step_q == STEP_REM) begin
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end else begin
          step_d  = step_q + 3'd1;
          state_d = S_KICK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      step_q   <= STEP_VOLT;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;
endmodule
`default_nettype wire

/* hdl/battery_gauge_monitor_core.sv */
`default_nettype none
// Request flow: once a request is accepted, the voltage step runs (kick, 24-bit bit-serial
// division, done), then the charge, health, capacity and remaining steps; the charge step
// uses a shift, the others reciprocal multiplication.
// Requests: a new one is taken only in idle, after the previous one is finished; a waiting
// result holds off the next request.
// Reset: async active low; average, voltage, flags and calibration clear, capacity 2000 mAh.
module battery_gauge_monitor_core import bgm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              kind_i,
  input  wire logic [ADC_W-1:0]  sample_0_i,
  input  wire logic [ADC_W-1:0]  sample_1_i,
  input  wire logic [ADC_W-1:0]  sample_2_i,
  input  wire logic [ADC_W-1:0]  sample_3_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [ADC_W-1:0]       averaged_adc_o,
  output logic [VOLT_W-1:0]      voltage_10mv_o,
  output logic [PCT_W-1:0]       charge_percent_o,
  output logic [2:0]             display_level_o,
  output logic [PCT_W-1:0]       health_percent_o,
  output logic [CAP_W-1:0]       remaining_mah_o,
  output logic                   low_battery_o,
  output logic                   low_blink_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  // configuration registers
  logic [ADC_W-1:0] cal_q [5];
  logic [CAP_W-1:0] cap_q;
  logic [2:0]       ridx;
  logic             wr_en;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) cal_q[i] <= '0;
      cap_q <= CAP_W'(2000);
    end else if (wr_en) begin
      if (ridx <= REG_CAL4) cal_q[ridx] <= pwdata[ADC_W-1:0];
      else if (ridx == REG_CAP) cap_q <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (ridx <= REG_CAL4)     prdata = 32'(cal_q[ridx]);
    else if (ridx == REG_CAP) prdata = 32'(cap_q);
  end

  bgm_cmd_t cmd;
  bgm_sts_t sts;

  bgm_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .sts_i(sts), .cmd_o(cmd)
  );

  bgm_datapath u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .sts_o(sts), .kind_i(kind_i),
    .sample_0_i(sample_0_i), .sample_1_i(sample_1_i), .sample_2_i(sample_2_i),
    .sample_3_i(sample_3_i), .cal_i(cal_q), .cap_i(cap_q),
    .avg_o(averaged_adc_o), .volt_o(voltage_10mv_o), .pct_o(charge_percent_o),
    .level_o(display_level_o), .health_o(health_percent_o), .rem_o(remaining_mah_o),
    .low_o(low_battery_o), .blink_o(low_blink_o)
  );

  // no new request while a result waits
  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("request accepted over pending result");
  // a result appears only after the last step
  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(sts.div_done)) else $error("result without division");
  a_volt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    voltage_10mv_o <= V_SAT) else $error("voltage above saturation");
endmodule
`default_nettype wire
